// ===== rtl/csps_pkg.sv =====
package csps_pkg;

  // Fixed-point format of terms and sums
  localparam int FRACTION_BITS = 16;

  // Term magnitude is saturated to 2^31-1, so 31 bits hold it
  localparam int TERM_WIDTH   = 31;
  localparam int SQUARE_WIDTH = 7;
  localparam int PROD_WIDTH   = TERM_WIDTH + SQUARE_WIDTH;
  localparam int DIV_WIDTH    = 9;
  localparam int COUNT_WIDTH  = $clog2(PROD_WIDTH);

  localparam int MAX_INDEX  = 9;
  localparam int SQUARE_MAX = 127;

  localparam logic [TERM_WIDTH-1:0] TERM_ONE = TERM_WIDTH'(64'd1 << FRACTION_BITS);
  localparam logic [TERM_WIDTH-1:0] TERM_MAX = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_ACC,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic div_step;
    logic acc;
  } csps_cmd_t;

  typedef struct packed {
    logic is_last;
  } csps_status_t;

endpackage

// ===== rtl/cosine_series_partial_sums_top.sv =====
// The first result (k = 0) is presented in the cycle after the item is accepted.
// Each further partial sum is computed only once the previous one is taken:
// 1 multiply, 38 restoring-division steps (one quotient bit each), 1 accumulate.
// The serial divider dominates how long an item occupies the block.
// One item in flight at a time.
// Reset: synchronous active-high rst returns the controller to idle, no result pending.
module cosine_series_partial_sums_top import csps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         argument,
  input  logic [3:0]         term_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] partial_sum,
  output logic [3:0]         term_index,
  output logic               last
);

  // Controller sequences load -> out, then (mul -> div x38 -> acc -> out) per further term;
  // the datapath holds x^2, n, k, the current term magnitude and the sum.
  csps_cmd_t    cmd;
  csps_status_t status;

  csps_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Sum register doubles as the output register: it only changes in load and acc,
  // neither of which happens while a result is presented.
  csps_datapath u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .argument    (argument),
    .term_count  (term_count),
    .status      (status),
    .partial_sum (partial_sum),
    .term_index  (term_index)
  );

  // final item of the series: k has reached the clamped term count
  assign last = status.is_last;

endmodule

// ===== rtl/csps_datapath.sv =====
module csps_datapath import csps_pkg::*; (
  input  logic               clk,
  input  csps_cmd_t          cmd,
  input  logic [3:0]         argument,
  input  logic [3:0]         term_count,
  output csps_status_t       status,
  output logic signed [31:0] partial_sum,
  output logic [3:0]         term_index
);

  logic [TERM_WIDTH-1:0]   term;
  logic signed [31:0]      sum;
  logic [3:0]              k;
  logic [SQUARE_WIDTH-1:0] square;
  logic [3:0]              count_held;
  logic [PROD_WIDTH-1:0]   quo;
  logic [DIV_WIDTH-1:0]    rem;
  logic [DIV_WIDTH-1:0]    divisor;

  logic [7:0]              sq_full;
  logic [3:0]              k_inc;
  logic [4:0]              two_k;
  logic [9:0]              div_full;
  logic [DIV_WIDTH:0]      rem_shift;
  logic                    q_bit;
  logic [TERM_WIDTH-1:0]   mag;
  logic signed [32:0]      sum_wide;
  logic signed [31:0]      sum_sat;

  assign sq_full  = {4'd0, argument} * {4'd0, argument};
  assign k_inc    = k + 4'd1;
  assign two_k    = {k_inc, 1'b0};
  assign div_full = {5'd0, two_k - 5'd1} * {5'd0, two_k};

  // restoring division, one quotient bit per step; quotient shifts into quo
  assign rem_shift = {rem, quo[PROD_WIDTH-1]};
  assign q_bit     = (rem_shift >= {1'b0, divisor});

  assign mag = (quo[PROD_WIDTH-1:TERM_WIDTH] != '0) ? TERM_MAX : quo[TERM_WIDTH-1:0];

  always_comb begin
    if (k[0]) begin
      sum_wide = {sum[31], sum} - $signed({2'b00, mag});
    end else begin
      sum_wide = {sum[31], sum} + $signed({2'b00, mag});
    end
    if (sum_wide[32] != sum_wide[31]) begin
      sum_sat = sum_wide[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sum_sat = sum_wide[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      square     <= (sq_full > 8'(SQUARE_MAX)) ? SQUARE_WIDTH'(SQUARE_MAX)
                                               : sq_full[SQUARE_WIDTH-1:0];
      count_held <= (term_count > 4'(MAX_INDEX)) ? 4'(MAX_INDEX) : term_count;
      k          <= '0;
      term       <= TERM_ONE;
      sum        <= 32'({1'b0, TERM_ONE});
    end
    if (cmd.mul) begin
      quo     <= {{SQUARE_WIDTH{1'b0}}, term} * {{TERM_WIDTH{1'b0}}, square};
      rem     <= '0;
      divisor <= div_full[DIV_WIDTH-1:0];
      k       <= k_inc;
    end
    if (cmd.div_step) begin
      rem <= q_bit ? DIV_WIDTH'(rem_shift - {1'b0, divisor}) : rem_shift[DIV_WIDTH-1:0];
      quo <= {quo[PROD_WIDTH-2:0], q_bit};
    end
    if (cmd.acc) begin
      term <= mag;
      sum  <= sum_sat;
    end
  end

  assign status.is_last = (k == count_held);
  assign partial_sum    = sum;
  assign term_index     = k;

endmodule

// ===== rtl/csps_controller.sv =====
module csps_controller import csps_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  csps_status_t status,
  output csps_cmd_t    cmd
);

  state_t                 state, state_next;
  logic [COUNT_WIDTH-1:0] count, count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_OUT;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        count_next = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        count_next   = count + 1'b1;
        if (count == COUNT_WIDTH'(PROD_WIDTH - 1)) begin
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = status.is_last ? S_IDLE : S_MUL;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("ready while a result is pending");

  a_load_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid) else $error("first result not presented");

  a_div_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && count == COUNT_WIDTH'(PROD_WIDTH - 1)) |=> cmd.acc)
    else $error("division did not end in accumulate");

  a_acc_result: assert property (@(posedge clk) disable iff (rst)
    cmd.acc |=> out_valid) else $error("accumulate not followed by result");

endmodule

// ===== bench/cosine_series_partial_sums_top_test.sv =====
module cosine_series_partial_sums_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import csps_pkg::*;

  // Run sizing. The slowest item (n = 9) keeps the block busy longest and
  // yields ten results. Each result can add a random stall before it is
  // taken, and the sender can add a random gap before the item. The limit
  // leaves a wide margin over the whole run.
  localparam int RANDOM_ITEMS = 385;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int LONG_HOLD    = 600;  // receiver back-pressure stretch, in cycles
  localparam int HOLD_AT      = 40;   // results taken before the long hold starts
  localparam int TAIL_CYCLES  = 100;  // quiet time after the last expected sum

  localparam longint unsigned TERM_CEIL = 64'h7FFF_FFFF;
  localparam longint          SUM_CEIL  = 64'sh7FFF_FFFF;
  localparam longint          SUM_FLOOR = -64'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] value;
    logic [3:0]         index;
    logic               is_last;
  } partial_sum_t;

  // Expected partial sums, oldest first, and the check of each accepted sum
  class partial_sum_board;
    partial_sum_t pending_sums[$];
    int           mismatches;

    // Expands one item into its n+1 partial sums (n clamped to nine). Each term is the previous
    // magnitude times x*x over (2k-1)(2k), truncated. Even k adds, odd k
    // subtracts. Terms and sums saturate.
    function void expand_series(logic [3:0] x, logic [3:0] n);
      longint unsigned square;
      longint unsigned magnitude;
      longint unsigned divisor;
      longint          total;
      int              top;
      partial_sum_t    rec;
      square = {60'd0, x};
      square = square * square;
      if (square > SQUARE_MAX) square = SQUARE_MAX;
      top = (n > MAX_INDEX) ? MAX_INDEX : int'(n);
      magnitude = 0;
      total = 0;
      for (int k = 0; k <= top; k++) begin
        if (k == 0) begin
          magnitude = 64'd1 << FRACTION_BITS;
        end else begin
          divisor = 64'((2 * k - 1) * (2 * k));
          magnitude = magnitude * square / divisor;
        end
        if (magnitude > TERM_CEIL) magnitude = TERM_CEIL;
        if (k % 2 == 0) total = total + longint'(magnitude);
        else total = total - longint'(magnitude);
        if (total > SUM_CEIL) total = SUM_CEIL;
        if (total < SUM_FLOOR) total = SUM_FLOOR;
        rec.value   = total[31:0];
        rec.index   = k[3:0];
        rec.is_last = (k == top);
        pending_sums.push_back(rec);
      end
    endfunction

    function void check_sum(logic signed [31:0] sum, logic [3:0] index, logic is_last);
      partial_sum_t want;
      if (pending_sums.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected partial sum, expected none, actual %0d (k %0d)",
                 $time, sum, index);
        return;
      end
      want = pending_sums.pop_front();
      if (sum !== want.value) begin
        mismatches++;
        $display("%0t: partial_sum expected %0d actual %0d", $time, want.value, sum);
      end
      if (index !== want.index) begin
        mismatches++;
        $display("%0t: term_index expected %0d actual %0d", $time, want.index, index);
      end
      if (is_last !== want.is_last) begin
        mismatches++;
        $display("%0t: last expected %0b actual %0b", $time, want.is_last, is_last);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [3:0]         argument = '0;
  logic [3:0]         term_count = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] partial_sum;
  logic [3:0]         term_index;
  logic               last;

  partial_sum_board board = new;
  int unsigned      cycle_count = 0;
  bit               send_steady = 1'b0;  // sender burst mode, no gaps

  cosine_series_partial_sums_top uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .argument   (argument),
    .term_count (term_count),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .partial_sum(partial_sum),
    .term_index (term_index),
    .last       (last)
  );

  always #1 clk = ~clk;

  // Timeout watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offers one item after a random gap, then holds it until accepted.
  // With a zero gap, valid stays high into the next item, so there is
  // no low-then-high in the same step.
  task automatic offer_item(input logic [3:0] x, input logic [3:0] n);
    int gap;
    if ($urandom_range(0, 15) == 0) send_steady = !send_steady;
    gap = send_steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    argument   <= x;
    term_count <= n;
    do @(posedge clk); while (!in_ready);
    board.expand_series(x, n);
  endtask

  // Result side. There is a random stall before each sum, with occasional
  // stall-free stretches. Once, after HOLD_AT sums, ready stays low for a
  // long while. The sender keeps offering during that time, but the block
  // holds its pending result and keeps in_ready low.
  initial begin : result_side
    int hold;
    int taken;
    bit steady;
    taken  = 0;
    steady = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) steady = !steady;
      hold = steady ? 0 : $urandom_range(0, 11);
      if (taken == HOLD_AT) hold = LONG_HOLD;
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      board.check_sum(partial_sum, term_index, last);
      taken++;
    end
  end

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Every argument runs with the full nine terms. This
    // covers zero (all sums 1.0) and values above eleven, where the square
    // saturates at 127.
    for (int x = 0; x < 16; x++) offer_item(x[3:0], 4'd9);
    // Term count extremes: a single sum, one step, and counts above nine
    // clamped to nine
    offer_item(4'd0, 4'd0);
    offer_item(4'd1, 4'd0);
    offer_item(4'd9, 4'd0);
    offer_item(4'd5, 4'd1);
    offer_item(4'd15, 4'd15);
    offer_item(4'd7, 4'd10);
    offer_item(4'd3, 4'd12);

    // Random part. Mostly nominal arguments and counts, with the rest
    // drawn across the full 4-bit range.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 9) < 7)
        offer_item(4'($urandom_range(1, 9)), 4'($urandom_range(1, 9)));
      else
        offer_item(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    end
    in_valid <= 1'b0;

    // Drain, then stay quiet to catch any extra sums
    while (board.pending_sums.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/csps_pkg.sv
rtl/csps_datapath.sv
rtl/csps_controller.sv
rtl/cosine_series_partial_sums_top.sv
bench/cosine_series_partial_sums_top_test.sv
